// File: src/fcba_pkg.sv
`default_nettype none

package fcba_pkg;

   // table geometry
   localparam int NUM_BLOCKS       = 2048;
   localparam int BLOCK_BYTES      = 4096;
   localparam int FIRST_DATA_BLOCK = 2;

   localparam int LINK_W     = 12;
   localparam int ADDR_W     = $clog2(NUM_BLOCKS);
   localparam int CNT_W      = ADDR_W + 1;
   localparam int BYTE_SHIFT = $clog2(BLOCK_BYTES);

   // block numbers at or above this are out of range
   localparam int USABLE      = (NUM_BLOCKS < 4095) ? NUM_BLOCKS : 4095;
   localparam int DATA_BLOCKS = USABLE - FIRST_DATA_BLOCK;

   // word field widths
   localparam int REQ_TYPE_W = 3;
   localparam int BLOCK_W    = 11;
   localparam int BYTES_W    = 23;
   localparam int STATUS_W   = 2;

   localparam logic [LINK_W-1:0] END_MARK  = 12'hFFF;
   localparam logic [LINK_W-1:0] FREE_MARK = 12'h000;

   // request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_FORMAT = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC  = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_EXTEND = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_FREE   = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ   = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_BLOCK = 2'd2;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [LINK_W-1:0] wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      logic [BLOCK_W-1:0]  result_block;
      logic                chain_end;
      logic [STATUS_W-1:0] status;
      logic [BLOCK_W-1:0]  free_count;
   } rsp_word_type;

   // ceil(bytes / block size), never below one
   function automatic logic [CNT_W-1:0] blocks_needed(input logic [BYTES_W-1:0] bytes);
      logic [CNT_W-1:0] n;
      n = CNT_W'(bytes >> BYTE_SHIFT) + CNT_W'(bytes[BYTE_SHIFT-1:0] != '0);
      if (n == '0) begin
         n = CNT_W'(1);
      end
      return n;
   endfunction

   // link names an in-range data block (table contents not checked)
   function automatic logic link_ok(input logic [LINK_W-1:0] link);
      return (link != END_MARK) && (link >= LINK_W'(FIRST_DATA_BLOCK))
         && (link < LINK_W'(USABLE));
   endfunction

endpackage

`default_nettype wire

// File: src/fcba_if.sv
`default_nettype none

interface fcba_req_if;
   logic                               valid;
   logic                               ready;
   logic [fcba_pkg::REQ_TYPE_W-1:0]    req_type;
   logic [fcba_pkg::BLOCK_W-1:0]       block;
   logic [fcba_pkg::BYTES_W-1:0]       byte_size;

   modport source (output valid, output req_type, output block, output byte_size,
                   input ready);
   modport sink (input valid, input req_type, input block, input byte_size,
                 output ready);
endinterface

interface fcba_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [fcba_pkg::BLOCK_W-1:0]     result_block;
   logic                             chain_end;
   logic [fcba_pkg::STATUS_W-1:0]    status;
   logic [fcba_pkg::BLOCK_W-1:0]     free_count;

   modport source (output valid, output result_block, output chain_end, output status,
                   output free_count, input ready);
   modport sink (input valid, input result_block, input chain_end, input status,
                 input free_count, output ready);
endinterface

`default_nettype wire

// File: src/fcba_link_ram.sv
`default_nettype none

module fcba_link_ram (
   input  wire logic                          clock,
   input  wire fcba_pkg::mem_req_type         mem_req,
   output logic [fcba_pkg::LINK_W-1:0]        rd_data
);

   logic [fcba_pkg::LINK_W-1:0] mem [fcba_pkg::NUM_BLOCKS];
   logic [fcba_pkg::LINK_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
   end

   // write-first: a read of the entry written in the same cycle sees the new link
   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         if (mem_req.we && (mem_req.waddr == mem_req.raddr)) begin
            rd_data_ff <= mem_req.wdata;
         end else begin
            rd_data_ff <= mem[mem_req.raddr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/fcba_seq.sv
`default_nettype none

module fcba_seq (
   input  wire logic                          clock,
   input  wire logic                          reset,
   fcba_req_if.sink                           req_chan,
   output fcba_pkg::mem_req_type              mem_req,
   input  wire logic [fcba_pkg::LINK_W-1:0]   rd_data,
   input  wire logic                          rsp_space,
   output logic                               rsp_load,
   output fcba_pkg::rsp_word_type             rsp_word
);

   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_DECODE   = 3'd2;
   localparam logic [2:0] ST_EXT_CHK  = 3'd3;
   localparam logic [2:0] ST_WALK     = 3'd4;
   localparam logic [2:0] ST_SCAN     = 3'd5;
   localparam logic [2:0] ST_SCAN_END = 3'd6;
   localparam logic [2:0] ST_DONE     = 3'd7;

   localparam int AW = fcba_pkg::ADDR_W;
   localparam int CW = fcba_pkg::CNT_W;

   logic [2:0]                           state_ff, state_in;
   logic                                 clr_rsp_ff, clr_rsp_in;
   logic                                 scan_vld_ff, scan_vld_in;
   logic [AW-1:0]                        scan_ptr_ff, scan_ptr_in;
   logic [AW-1:0]                        free_ff, free_in;

   logic [fcba_pkg::REQ_TYPE_W-1:0]      type_ff, type_in;
   logic [AW-1:0]                        blk_ff, blk_in;
   logic [CW-1:0]                        need_ff, need_in;
   logic [AW-1:0]                        cur_ff, cur_in;
   logic [AW-1:0]                        cand_ff, cand_in;
   logic [CW-1:0]                        steps_ff, steps_in;
   logic [AW-1:0]                        scan_addr_ff, scan_addr_in;
   logic [CW-1:0]                        got_ff, got_in;
   logic [AW-1:0]                        prev_ff, prev_in;
   logic [AW-1:0]                        first_ff, first_in;
   logic [fcba_pkg::BLOCK_W-1:0]         res_ff, res_in;
   logic                                 end_ff, end_in;
   logic [fcba_pkg::STATUS_W-1:0]        st_ff, st_in;

   logic [CW-1:0]                        steps_nx;
   logic [CW-1:0]                        got_nx;
   logic                                 no_room;

   assign steps_nx = steps_ff + CW'(1);
   assign got_nx   = got_ff + CW'(1);
   assign no_room  = need_ff > {1'b0, free_ff};

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      clr_rsp_in   = clr_rsp_ff;
      scan_vld_in  = scan_vld_ff;
      scan_ptr_in  = scan_ptr_ff;
      free_in      = free_ff;
      type_in      = type_ff;
      blk_in       = blk_ff;
      need_in      = need_ff;
      cur_in       = cur_ff;
      cand_in      = cand_ff;
      steps_in     = steps_ff;
      scan_addr_in = scan_addr_ff;
      got_in       = got_ff;
      prev_in      = prev_ff;
      first_in     = first_ff;
      res_in       = res_ff;
      end_in       = end_ff;
      st_in        = st_ff;
      mem_req      = '0;
      rsp_load     = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = scan_ptr_ff;
            mem_req.wdata = (scan_ptr_ff < AW'(fcba_pkg::FIRST_DATA_BLOCK))
                          ? fcba_pkg::END_MARK : fcba_pkg::FREE_MARK;
            scan_ptr_in   = scan_ptr_ff + AW'(1);
            if (scan_ptr_ff == AW'(fcba_pkg::NUM_BLOCKS - 1)) begin
               free_in  = AW'(fcba_pkg::DATA_BLOCKS);
               state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_chan.valid) begin
               type_in       = req_chan.req_type;
               blk_in        = AW'(req_chan.block);
               need_in       = fcba_pkg::blocks_needed(req_chan.byte_size);
               mem_req.re    = 1'b1;
               mem_req.raddr = AW'(req_chan.block);
               state_in      = ST_DECODE;
            end
         end

         ST_DECODE: begin
            res_in       = '0;
            end_in       = 1'b0;
            st_in        = fcba_pkg::STATUS_OK;
            state_in     = ST_DONE;
            scan_ptr_in  = AW'(fcba_pkg::FIRST_DATA_BLOCK);
            scan_vld_in  = 1'b0;
            got_in       = '0;
            cur_in       = blk_ff;
            steps_in     = '0;
            case (type_ff)
               fcba_pkg::REQ_FORMAT: begin
                  scan_ptr_in = '0;
                  clr_rsp_in  = 1'b1;
                  state_in    = ST_CLEAR;
               end
               fcba_pkg::REQ_ALLOC: begin
                  if (no_room) begin
                     st_in = fcba_pkg::STATUS_NO_SPACE;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
               fcba_pkg::REQ_EXTEND, fcba_pkg::REQ_FREE, fcba_pkg::REQ_READ: begin
                  if (!fcba_pkg::link_ok(fcba_pkg::LINK_W'(blk_ff))
                      || (rd_data == fcba_pkg::FREE_MARK)) begin
                     st_in = fcba_pkg::STATUS_BAD_BLOCK;
                  end else if (type_ff == fcba_pkg::REQ_READ) begin
                     if (rd_data == fcba_pkg::END_MARK) begin
                        end_in = 1'b1;
                     end else begin
                        res_in = rd_data[fcba_pkg::BLOCK_W-1:0];
                     end
                  end else if (type_ff == fcba_pkg::REQ_FREE) begin
                     // rd_data still holds the start block's link
                     state_in = ST_WALK;
                  end else if (no_room) begin
                     st_in = fcba_pkg::STATUS_NO_SPACE;
                  end else if (fcba_pkg::link_ok(rd_data)) begin
                     cand_in       = rd_data[AW-1:0];
                     mem_req.re    = 1'b1;
                     mem_req.raddr = rd_data[AW-1:0];
                     state_in      = ST_EXT_CHK;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
               default: begin
               end
            endcase
         end

         // extend: follow links to the chain's tail, then scan
         ST_EXT_CHK: begin
            if (rd_data == fcba_pkg::FREE_MARK) begin
               state_in = ST_SCAN;
            end else begin
               cur_in   = cand_ff;
               steps_in = steps_nx;
               if (fcba_pkg::link_ok(rd_data) && (steps_nx < CW'(fcba_pkg::USABLE))) begin
                  cand_in       = rd_data[AW-1:0];
                  mem_req.re    = 1'b1;
                  mem_req.raddr = rd_data[AW-1:0];
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         // free: release cur while fetching the link after it
         ST_WALK: begin
            if (rd_data == fcba_pkg::FREE_MARK) begin
               state_in = ST_DONE;
            end else begin
               mem_req.we    = 1'b1;
               mem_req.waddr = cur_ff;
               mem_req.wdata = fcba_pkg::FREE_MARK;
               free_in       = free_ff + AW'(1);
               steps_in      = steps_nx;
               if (fcba_pkg::link_ok(rd_data) && (steps_nx < CW'(fcba_pkg::USABLE))) begin
                  cur_in        = rd_data[AW-1:0];
                  mem_req.re    = 1'b1;
                  mem_req.raddr = rd_data[AW-1:0];
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         // first-fit: one read per cycle, links written one behind
         ST_SCAN: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = scan_ptr_ff;
            scan_ptr_in   = scan_ptr_ff + AW'(1);
            scan_vld_in   = 1'b1;
            scan_addr_in  = scan_ptr_ff;
            if (scan_vld_ff) begin
               if (rd_data == fcba_pkg::FREE_MARK) begin
                  if (got_ff == '0) begin
                     first_in = scan_addr_ff;
                     if (type_ff == fcba_pkg::REQ_EXTEND) begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = cur_ff;
                        mem_req.wdata = fcba_pkg::LINK_W'(scan_addr_ff);
                     end
                  end else begin
                     mem_req.we    = 1'b1;
                     mem_req.waddr = prev_ff;
                     mem_req.wdata = fcba_pkg::LINK_W'(scan_addr_ff);
                  end
                  prev_in = scan_addr_ff;
                  got_in  = got_nx;
                  if (got_nx == need_ff) begin
                     state_in = ST_SCAN_END;
                  end
               end
               if (scan_addr_ff == AW'(fcba_pkg::USABLE - 1)) begin
                  state_in = ST_SCAN_END;
               end
            end
         end

         ST_SCAN_END: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = prev_ff;
            mem_req.wdata = fcba_pkg::END_MARK;
            free_in       = free_ff - got_ff[AW-1:0];
            res_in        = fcba_pkg::BLOCK_W'(first_ff);
            state_in      = ST_DONE;
         end

         ST_DONE: begin
            if (rsp_space) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_word.result_block = res_ff;
   assign rsp_word.chain_end    = end_ff;
   assign rsp_word.status       = st_ff;
   assign rsp_word.free_count   = fcba_pkg::BLOCK_W'(free_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_rsp_ff  <= 1'b0;
         scan_vld_ff <= 1'b0;
         scan_ptr_ff <= '0;
         free_ff     <= AW'(fcba_pkg::DATA_BLOCKS);
      end else begin
         state_ff    <= state_in;
         clr_rsp_ff  <= clr_rsp_in;
         scan_vld_ff <= scan_vld_in;
         scan_ptr_ff <= scan_ptr_in;
         free_ff     <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff      <= type_in;
      blk_ff       <= blk_in;
      need_ff      <= need_in;
      cur_ff       <= cur_in;
      cand_ff      <= cand_in;
      steps_ff     <= steps_in;
      scan_addr_ff <= scan_addr_in;
      got_ff       <= got_in;
      prev_ff      <= prev_in;
      first_ff     <= first_in;
      res_ff       <= res_in;
      end_ff       <= end_in;
      st_ff        <= st_in;
   end

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_req.we)
      else $error("link table written while idle");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= AW'(fcba_pkg::DATA_BLOCKS))
      else $error("free count above data block count");

   a_scan_need: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ((got_ff < need_ff) && (need_ff <= {1'b0, free_ff})))
      else $error("scan running past its block count");

   a_scan_end_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_END) |=> (state_ff == ST_DONE))
      else $error("scan end did not finish the request");

endmodule

`default_nettype wire

// File: src/fcba_rsp_stage.sv
`default_nettype none

module fcba_rsp_stage (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      rsp_load,
   input  wire fcba_pkg::rsp_word_type    rsp_word,
   output logic                           rsp_space,
   fcba_rsp_if.source                     rsp_chan
);

   logic                   valid_ff, valid_in;
   fcba_pkg::rsp_word_type word_ff;

   // a new word may replace the held one in the cycle it is taken
   assign rsp_space = !valid_ff || rsp_chan.ready;
   assign valid_in  = rsp_load || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         word_ff <= rsp_word;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.result_block = word_ff.result_block;
   assign rsp_chan.chain_end    = word_ff.chain_end;
   assign rsp_chan.status       = word_ff.status;
   assign rsp_chan.free_count   = word_ff.free_count;

endmodule

`default_nettype wire

// File: src/fat_chain_block_allocator_unit.sv
`default_nettype none

// Block allocator over a 2048-entry table of next-block links held in one
// synchronous RAM (one write and one read per cycle), served one request at a
// time. After reset the table is cleared by a pass over every entry during which
// no request is taken; a format request runs the same pass and then answers.
// Free releases the blocks of the chain one by one. Allocate scans the table
// entries from block 2 up to the last block it takes (at most 2046 entries).
// Extend follows links to the chain's tail, then runs the same scan.
// The result sits in an output register, so the next request can be taken
// while a result still waits on rsp_chan.
module fat_chain_block_allocator_unit (
   input  wire logic clock,
   input  wire logic reset,
   fcba_req_if.sink   req_chan,
   fcba_rsp_if.source rsp_chan
);

   fcba_pkg::mem_req_type          mem_req;
   logic [fcba_pkg::LINK_W-1:0]    rd_data;
   logic                           rsp_space;
   logic                           rsp_load;
   fcba_pkg::rsp_word_type         rsp_word;

   fcba_link_ram u_link_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   fcba_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .mem_req   (mem_req),
      .rd_data   (rd_data),
      .rsp_space (rsp_space),
      .rsp_load  (rsp_load),
      .rsp_word  (rsp_word)
   );

   fcba_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .rsp_load  (rsp_load),
      .rsp_word  (rsp_word),
      .rsp_space (rsp_space),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire
